@@ src/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1md_pkg
// constants and types shared by the sha-1 digest unit and its
// testbench
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int unsigned NumWords  = 5;
  localparam int unsigned NumRounds = 80;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K_ROUND0 = 32'h5A827999;
  localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd4;
  localparam logic [6:0] LAST_ROUND = 7'(NumRounds - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] r;
    unique case (idx)
      3'd0:    r = H0_INIT;
      3'd1:    r = H1_INIT;
      3'd2:    r = H2_INIT;
      3'd3:    r = H3_INIT;
      default: r = H4_INIT;
    endcase
    return r;
  endfunction

endpackage

@@ src/sha1md_if.sv @@
// ----------------------------------------------------------------------------
// sha1md_if
// valid/ready channels of the sha-1 digest unit: message bytes in, digest
// words out
// ----------------------------------------------------------------------------
interface sha1md_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1md_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ src/sha1_message_digest_unit.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// sha-1 over a byte stream: one shared round unit, 80 rounds per block,
// padding fed through the same byte path, digest out as five words
// ----------------------------------------------------------------------------
//  channel  dir  payload                                     transfer
//  msg      in   data_byte, byte_present, end_of_message     one item
//  digest   out  digest_word, word_index, last_word          one word
//
//  an item without block completion leaves the unit idle; a byte that fills
//  the block starts a compression (80 rounds in the shared round unit plus
//  the add); an end item pads one byte per cycle (up to 72 bytes) with one
//  or two compressions, then five digest transfers
//  msg.ready is high only while idle; digest words wait for digest.ready
//  synchronous reset restores the initial chaining words and clears counts
// ----------------------------------------------------------------------------
module sha1_message_digest_unit
  import sha1md_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  sha1md_msg_if.sink   msg,
  sha1md_dig_if.source digest
);

  state_t       state;
  logic [5:0]   fill;
  logic [63:0]  bit_total;
  logic [511:0] blk;
  logic [31:0]  chain [NumWords];
  logic [31:0]  a, b, c, d, e;
  logic [6:0]   round;
  logic [2:0]   word_idx;
  logic         pad_first;
  logic         len_phase;
  logic         pad_active;

  logic         in_fire;
  logic         put_en;
  logic [7:0]   put_val;
  logic         is_len;
  logic [5:0]   len_sh;
  logic [7:0]   len_byte;
  logic [31:0]  w0, w2, w8, w13, w_new;
  logic [31:0]  f, k, t;

  assign msg.ready = (state == ST_IDLE);
  assign in_fire   = msg.valid & msg.ready;

  assign len_sh   = {3'(3'd7 - fill[2:0]), 3'b000};
  assign len_byte = 8'(bit_total >> len_sh);
  assign is_len   = !pad_first && (len_phase || fill == LEN_POS);

  always_comb begin
    put_en  = 1'b0;
    put_val = msg.data_byte;
    if (state == ST_PAD) begin
      put_en = 1'b1;
      if (pad_first) begin
        put_val = PAD_BYTE;
      end else if (is_len) begin
        put_val = len_byte;
      end else begin
        put_val = 8'h00;
      end
    end else if (in_fire && msg.byte_present) begin
      put_en = 1'b1;
    end
  end

  // message schedule window, word t at the top
  assign w0    = blk[511:480];
  assign w2    = blk[447:416];
  assign w8    = blk[255:224];
  assign w13   = blk[95:64];
  assign w_new = {(w13 ^ w8 ^ w2 ^ w0) << 1} | 32'((w13 ^ w8 ^ w2 ^ w0) >> 31);

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_ROUND0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K_ROUND1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_ROUND2;
    end else begin
      f = b ^ c ^ d;
      k = K_ROUND3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w0;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      bit_total  <= '0;
      round      <= '0;
      word_idx   <= '0;
      pad_first  <= 1'b0;
      len_phase  <= 1'b0;
      pad_active <= 1'b0;
      for (int i = 0; i < NumWords; i++) begin
        chain[i] <= init_word(3'(i));
      end
    end else begin
      if (put_en) begin
        fill <= fill + 6'd1;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            pad_first  <= msg.end_of_message;
            pad_active <= msg.end_of_message;
            if (msg.byte_present) begin
              bit_total <= bit_total + 64'd8;
            end
            if (msg.byte_present && fill == LAST_POS) begin
              state <= ST_COMP;
            end else if (msg.end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          pad_first <= 1'b0;
          if (is_len) begin
            len_phase <= 1'b1;
          end
          if (fill == LAST_POS) begin
            state <= ST_COMP;
          end
        end
        ST_COMP: begin
          if (round == LAST_ROUND) begin
            round <= '0;
            state <= ST_ADD;
          end else begin
            round <= round + 7'd1;
          end
        end
        ST_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          if (len_phase) begin
            state <= ST_EMIT;
          end else if (pad_active) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (digest.ready) begin
            if (word_idx == LAST_WORD) begin
              word_idx   <= '0;
              bit_total  <= '0;
              len_phase  <= 1'b0;
              pad_active <= 1'b0;
              state      <= ST_IDLE;
              for (int i = 0; i < NumWords; i++) begin
                chain[i] <= init_word(3'(i));
              end
            end else begin
              word_idx <= word_idx + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (put_en) begin
      blk <= {blk[503:0], put_val};
    end else if (state == ST_COMP) begin
      blk <= {blk[479:0], w_new};
    end
    if (put_en && fill == LAST_POS) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (state == ST_COMP) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

  assign digest.valid       = (state == ST_EMIT);
  assign digest.digest_word = chain[word_idx];
  assign digest.word_index  = word_idx;
  assign digest.last_word   = (word_idx == LAST_WORD);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && digest.valid))
    else $error("input ready while digest pending");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> (digest.word_index <= LAST_WORD))
    else $error("digest word index out of range");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP) |-> (round <= LAST_ROUND))
    else $error("round counter out of range");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.last_word) |=>
      (msg.ready && fill == 6'd0 && bit_total == 64'd0 && chain[0] == H0_INIT))
    else $error("state not restored after digest");

  a_comp_entry: assert property (@(posedge clk) disable iff (rst)
    (state != ST_COMP) ##1 (state == ST_COMP) |-> (fill == 6'd0 && round == 7'd0))
    else $error("compression started off a block boundary");

endmodule

@@ tb/sha1_message_digest_unit_tb.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest_unit_tb
// self-checking bench for the sha-1 digest unit: a short table of directed
// messages (empty message, "abc", ignored items, single bytes) and then
// random messages whose lengths favor the padding corners. a software sha-1
// tracks every accepted byte and queues the five digest words; each digest
// transfer is compared field by field. both sides idle at random, and the
// receiver holds off for long stretches so the unit stalls its input.
// ----------------------------------------------------------------------------
module sha1_message_digest_unit_tb;
  import sha1md_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned HoldCycles = 300;

  localparam logic [159:0] DigestEmpty = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] DigestAbc   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic         byte_present;
    logic         end_of_message;
    logic         has_known;
    logic [159:0] known_digest;
  } msg_row_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  localparam int NumRows = 12;
  localparam msg_row_t DirectedRows [NumRows] = '{
    '{8'hA5, 1'b0, 1'b1, 1'b1, DigestEmpty},
    '{8'h61, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 160'd0},
    '{8'h63, 1'b1, 1'b1, 1'b1, DigestAbc},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 160'd0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 160'd0},
    '{8'h5A, 1'b0, 1'b1, 1'b0, 160'd0},
    '{8'hFF, 1'b1, 1'b1, 1'b0, 160'd0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 160'd0},
    '{8'h00, 1'b0, 1'b1, 1'b1, DigestEmpty}
  };

  localparam int NumCorners = 10;
  localparam int CornerLengths [NumCorners] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};

  logic clk;
  logic rst;

  sha1md_msg_if msg_ch ();
  sha1md_dig_if dig_ch ();

  sha1_message_digest_unit uut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (dig_ch)
  );

  // software sha-1 state
  logic [31:0] chain_q [NumWords];
  logic [7:0]  block_q [64];
  logic [5:0]  fill_q;
  logic [63:0] bit_count_q;

  digest_word_t pending_words [$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  bit           send_burst = 1'b0;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic restart_chain();
    for (int i = 0; i < NumWords; i++) chain_q[i] = init_word(3'(i));
    for (int i = 0; i < 64; i++) block_q[i] = 8'h00;
    fill_q = '0;
    bit_count_q = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [NumRounds];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_q[4*i], block_q[4*i+1], block_q[4*i+2], block_q[4*i+3]};
    end
    for (int i = 16; i < NumRounds; i++) begin
      w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    end
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int i = 0; i < NumRounds; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_ROUND0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_ROUND1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_ROUND2;
      end else begin
        f = b ^ c ^ d;
        k = K_ROUND3;
      end
      t = rotl32(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rotl32(b, 30); b = a; a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endtask

  task automatic absorb_byte(input logic [7:0] v);
    block_q[fill_q] = v;
    fill_q = fill_q + 6'd1;
    if (fill_q == 6'd0) compress_block();
  endtask

  task automatic sha1_predict(input msg_row_t row);
    logic [63:0] len;
    digest_word_t dw;
    if (row.byte_present) begin
      absorb_byte(row.data_byte);
      bit_count_q += 64'd8;
    end
    if (row.end_of_message) begin
      len = bit_count_q;
      absorb_byte(PAD_BYTE);
      while (fill_q != LEN_POS) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[63 - 8*i -: 8]);
      for (int i = 0; i < NumWords; i++) begin
        dw.digest_word = row.has_known ? row.known_digest[159 - 32*i -: 32] : chain_q[i];
        dw.word_index  = 3'(i);
        dw.last_word   = (3'(i) == LAST_WORD);
        pending_words.push_back(dw);
      end
      restart_chain();
    end
  endtask

  task automatic send_item(input msg_row_t row);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid          <= 1'b1;
    msg_ch.data_byte      <= row.data_byte;
    msg_ch.byte_present   <= row.byte_present;
    msg_ch.end_of_message <= row.end_of_message;
    do @(posedge clk); while (!msg_ch.ready);
    sha1_predict(row);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // digest side: random ready, long hold-offs now and then
  initial begin
    int unsigned transfers;
    int unsigned gap;
    bit          recv_burst;
    transfers = 0;
    recv_burst = 1'b0;
    dig_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (transfers % 8 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      if (transfers == 10 || transfers == 60) begin
        dig_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      gap = recv_burst ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        dig_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      dig_ch.ready <= 1'b1;
      do @(posedge clk); while (!dig_ch.valid);
      transfers++;
    end
  end

  // digest transfer check
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst && dig_ch.valid && dig_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("digest transfer with nothing expected: word %h index %0d",
               dig_ch.digest_word, dig_ch.word_index);
        fail_count++;
      end else begin
        exp_w = pending_words.pop_front();
        if (dig_ch.digest_word !== exp_w.digest_word) begin
          $error("digest_word: expected %h actual %h", exp_w.digest_word, dig_ch.digest_word);
          fail_count++;
        end
        if (dig_ch.word_index !== exp_w.word_index) begin
          $error("word_index: expected %0d actual %0d", exp_w.word_index, dig_ch.word_index);
          fail_count++;
        end
        if (dig_ch.last_word !== exp_w.last_word) begin
          $error("last_word: expected %0b actual %0b", exp_w.last_word, dig_ch.last_word);
          fail_count++;
        end
      end
    end
  end

  // message side: directed table, then random messages
  initial begin
    msg_row_t    row;
    int unsigned items_sent;
    int unsigned messages;
    int unsigned len;
    int unsigned pick;
    bit          end_alone;
    restart_chain();
    rst = 1'b1;
    msg_ch.valid = 1'b0;
    msg_ch.data_byte = 8'h00;
    msg_ch.byte_present = 1'b0;
    msg_ch.end_of_message = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NumRows; r++) begin
      send_burst = ($urandom_range(0, 3) == 0);
      send_item(DirectedRows[r]);
    end

    items_sent = 0;
    messages = 0;
    while (items_sent < RandomItems || messages < 12) begin
      send_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 4) len = CornerLengths[$urandom_range(0, NumCorners - 1)];
      else if (pick < 9) len = $urandom_range(0, 70);
      else len = $urandom_range(71, 140);
      end_alone = (len == 0) || ($urandom_range(0, 1) == 1);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          row = '{8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 160'd0};
          send_item(row);
        end
        row = '{8'($urandom_range(0, 255)), 1'b1,
                (i == len - 1) && !end_alone, 1'b0, 160'd0};
        send_item(row);
        items_sent++;
      end
      if (end_alone) begin
        row = '{8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 160'd0};
        send_item(row);
        items_sent++;
      end
      messages++;
    end

    msg_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
